### sv/tlni_pkg.sv
`timescale 1ns / 1ps
// tlni_pkg: shared widths, defaults and reset values for the lattice neighbour index block
// no dependencies; used by the channel interfaces, the top level and its checker

package tlni_pkg;

    // fixed field widths
    localparam int SITE_W    = 18;
    localparam int DIR_W     = 3;
    localparam int SIDE_IN_W = 7;

    // defaults for the top level parameters
    localparam int AXES_DEF     = 3;
    localparam int MAX_SIDE_DEF = 64;

    // side length after reset
    localparam int SIDE_RESET = 4;

    // long division: quotient bits resolved per stage, stages per axis
    localparam int DIV_BITS   = 6;
    localparam int DIV_STAGES = SITE_W / DIV_BITS;

endpackage

### sv/tlni_site_if.sv
`timescale 1ns / 1ps
// tlni_site_if: valid/ready channel carrying one site index item
// depends on tlni_pkg for the field width

interface tlni_site_if import tlni_pkg::*;;

    logic              valid;
    logic              ready;
    logic [SITE_W-1:0] site_index;

    modport source (output valid, output site_index, input ready);
    modport sink   (input valid, input site_index, output ready);

endinterface

### sv/tlni_nbr_if.sv
`timescale 1ns / 1ps
// tlni_nbr_if: valid/ready channel carrying one neighbour result item
// depends on tlni_pkg for the field widths

interface tlni_nbr_if import tlni_pkg::*;;

    logic              valid;
    logic              ready;
    logic [SITE_W-1:0] neighbor_site;
    logic [DIR_W-1:0]  direction;
    logic              last_of_run;
    logic              bad_index;

    modport source (output valid, output neighbor_site, output direction,
                    output last_of_run, output bad_index, input ready);
    modport sink   (input valid, input neighbor_site, input direction,
                    input last_of_run, input bad_index, output ready);

endinterface

### sv/torus_lattice_neighbor_index.sv
`timescale 1ns / 1ps
// torus_lattice_neighbor_index: an accepted item passes the pipelined long division
// (DIV_STAGES stages per axis), one neighbour stage and the output register before
// its first result is shown; a new item may enter while earlier ones are in flight.
// throughput: one result per cycle from the output serialiser while neighbors.ready
// is high; the division pipeline accepts an item every cycle unless it is stalled.
// reset: asynchronous, clears all valid bits and sets the side length to 4.

module torus_lattice_neighbor_index
    import tlni_pkg::*;
#(
    parameter int AXES     = AXES_DEF,
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [SIDE_IN_W-1:0] cfg_wdata,
    tlni_site_if.sink            sites,
    tlni_nbr_if.source           neighbors
);

    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int REM_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int NDIV     = AXES * DIV_STAGES;
    localparam int NRES     = 2 * AXES;
    localparam int CNT_W    = (NRES > 1) ? $clog2(NRES) : 1;
    localparam int SIDE_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NRES - 1);

    typedef struct packed {
        logic [SITE_W-1:0]            idx;
        logic [SITE_W-1:0]            rest;
        logic [REM_W-1:0]             rem;
        logic [AXES-1:0][REM_W-1:0]   coord;
        logic [AXES:0][SITE_W-1:0]    pw;
    } item_t;

    // one pipeline stage of the long division, plus the next power of the side
    function automatic item_t div_step(input item_t d, input logic [SIDE_W-1:0] side,
                                       input int k_axis, input int sub);
        item_t                      r;
        logic [REM_W:0]             tmp;
        logic [REM_W:0]             side_x;
        logic                       qb;
        logic [SITE_W+SIDE_W-1:0]   prod;
        r      = d;
        side_x = (REM_W + 1)'(side);
        prod   = (SITE_W + SIDE_W)'(d.pw[k_axis]) * (SITE_W + SIDE_W)'(side);
        if (sub == 0)
        begin
            r.rem            = '0;
            r.pw[k_axis + 1] = prod[SITE_W-1:0];
        end
        for (int i = 0; i < DIV_BITS; i++)
        begin
            tmp = {r.rem, r.rest[SITE_W-1]};
            qb  = (tmp >= side_x);
            if (qb)
            begin
                tmp = tmp - side_x;
            end
            r.rem  = tmp[REM_W-1:0];
            r.rest = {r.rest[SITE_W-2:0], qb};
        end
        if (sub == DIV_STAGES - 1)
        begin
            r.coord[AXES-1-k_axis] = r.rem;
        end
        return r;
    endfunction

    // side length register, clamped on write, a written zero taken as one
    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] side_next;

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            side_next = SIDE_W'(1);
        end
        else if (int'(cfg_wdata) > MAX_SIDE)
        begin
            side_next = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_next = SIDE_W'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_W'(SIDE_RST);
        end
        else if (cfg_we)
        begin
            side_reg <= side_next;
        end
    end

    // first item image from the input channel
    item_t first_item;

    always_comb
    begin
        first_item       = '0;
        first_item.idx   = sites.site_index;
        first_item.rest  = sites.site_index;
        first_item.pw[0] = SITE_W'(1);
    end

    // division pipeline, last axis first
    logic  vld_reg [NDIV];
    item_t dat_reg [NDIV];
    logic  stg_rdy [NDIV];
    logic  nb_rdy;

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        localparam int KAX = k / DIV_STAGES;
        localparam int SUB = k % DIV_STAGES;

        item_t stg_in;
        logic  stg_in_vld;
        logic  down_rdy;
        item_t dat_next;

        if (k == 0)
        begin : g_head
            assign stg_in     = first_item;
            assign stg_in_vld = sites.valid;
        end
        else
        begin : g_body
            assign stg_in     = dat_reg[k-1];
            assign stg_in_vld = vld_reg[k-1];
        end

        if (k == NDIV - 1)
        begin : g_tail
            assign down_rdy = nb_rdy;
        end
        else
        begin : g_mid
            assign down_rdy = stg_rdy[k+1];
        end

        assign stg_rdy[k] = !vld_reg[k] || down_rdy;
        assign dat_next   = div_step(stg_in, side_reg, KAX, SUB);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (stg_rdy[k])
            begin
                vld_reg[k] <= stg_in_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_rdy[k])
            begin
                dat_reg[k] <= dat_next;
            end
        end
    end

    assign sites.ready = stg_rdy[0];

    // neighbour stage: all minus and plus neighbours with wraparound
    logic              nb_vld_reg;
    logic              nb_bad_reg;
    logic              nb_bad_next;
    logic [SITE_W-1:0] nb_site_reg  [NRES];
    logic [SITE_W-1:0] nb_site_next [NRES];
    logic [SIDE_W-1:0] side_m1;
    logic              ser_take;
    item_t             fin;

    assign fin         = dat_reg[NDIV-1];
    assign nb_bad_next = (fin.rest != '0);
    assign side_m1     = side_reg - SIDE_W'(1);

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            logic [SITE_W-1:0] st;
            logic [SITE_W-1:0] wrap;
            logic [SITE_W-1:0] minus_n;
            logic [SITE_W-1:0] plus_n;
            st   = fin.pw[AXES-1-a];
            wrap = fin.pw[AXES-a] - fin.pw[AXES-1-a];
            if (fin.coord[a] == '0)
            begin
                minus_n = fin.idx + wrap;
            end
            else
            begin
                minus_n = fin.idx - st;
            end
            if (SIDE_W'(fin.coord[a]) == side_m1)
            begin
                plus_n = fin.idx - wrap;
            end
            else
            begin
                plus_n = fin.idx + st;
            end
            nb_site_next[2*a]     = nb_bad_next ? '0 : minus_n;
            nb_site_next[2*a + 1] = nb_bad_next ? '0 : plus_n;
        end
    end

    assign nb_rdy = !nb_vld_reg || ser_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_vld_reg <= 1'b0;
        end
        else if (nb_rdy)
        begin
            nb_vld_reg <= vld_reg[NDIV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nb_rdy)
        begin
            nb_bad_reg  <= nb_bad_next;
            nb_site_reg <= nb_site_next;
        end
    end

    // output serialiser, one result item per cycle while neighbors.ready is high
    logic              ser_vld_reg;
    logic              ser_bad_reg;
    logic [CNT_W-1:0]  ser_cnt_reg;
    logic [SITE_W-1:0] ser_site_reg [NRES];
    logic              ser_last;

    assign ser_last = (ser_cnt_reg == LAST_CNT);
    assign ser_take = !ser_vld_reg || (neighbors.ready && ser_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_vld_reg <= 1'b0;
            ser_cnt_reg <= '0;
        end
        else if (ser_take)
        begin
            ser_vld_reg <= nb_vld_reg;
            ser_cnt_reg <= '0;
        end
        else if (neighbors.ready)
        begin
            ser_cnt_reg <= ser_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_take)
        begin
            ser_bad_reg  <= nb_bad_reg;
            ser_site_reg <= nb_site_reg;
        end
    end

    assign neighbors.valid         = ser_vld_reg;
    assign neighbors.neighbor_site = ser_site_reg[ser_cnt_reg];
    assign neighbors.direction     = DIR_W'(ser_cnt_reg);
    assign neighbors.last_of_run   = ser_last;
    assign neighbors.bad_index     = ser_bad_reg;

endmodule

### sv/tlni_checker.sv
`timescale 1ns / 1ps
// tlni_checker: port-level assertions on the neighbour result channel, bound to the top level
// depends on tlni_pkg and torus_lattice_neighbor_index

module tlni_checker
    import tlni_pkg::*;
#(
    parameter int AXES = AXES_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [SITE_W-1:0] neighbor_site,
    input logic [DIR_W-1:0]  direction,
    input logic              last_of_run,
    input logic              bad_index
);

    localparam logic [DIR_W-1:0] LAST_DIR = DIR_W'(2 * AXES - 1);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(neighbor_site)
            && $stable(direction) && $stable(bad_index))
        else $error("result item changed while stalled");

    // directions of one run follow each other without gaps
    a_dir_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid
            && direction == DIR_W'($past(direction) + DIR_W'(1)))
        else $error("direction sequence broken within a run");

    // the last flag marks exactly the final direction
    a_last_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last_of_run == (direction == LAST_DIR))
        else $error("last flag does not match final direction");

    // a bad index reports site zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_index |-> neighbor_site == '0)
        else $error("bad index with non-zero neighbour site");

    // the error flag is the same throughout a run
    a_bad_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> bad_index == $past(bad_index))
        else $error("bad index flag changed within a run");

endmodule

bind torus_lattice_neighbor_index tlni_checker #(.AXES(AXES)) u_tlni_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (neighbors.valid),
    .out_ready     (neighbors.ready),
    .neighbor_site (neighbors.neighbor_site),
    .direction     (neighbors.direction),
    .last_of_run   (neighbors.last_of_run),
    .bad_index     (neighbors.bad_index)
);

### bench/tb_torus_lattice_neighbor_index.sv
`timescale 1ns / 1ps
// tb_torus_lattice_neighbor_index: self-checking bench for the lattice neighbour index block
// depends on tlni_pkg, tlni_site_if, tlni_nbr_if and torus_lattice_neighbor_index

module tb_torus_lattice_neighbor_index import tlni_pkg::*;;

    localparam int AXES     = AXES_DEF;
    localparam int MAX_SIDE = MAX_SIDE_DEF;
    // cycles from item to first result, plus margin for the serialiser
    localparam int DRAIN    = AXES * DIV_STAGES + 2 + 2 * AXES + 4;

    typedef struct packed {
        logic [SITE_W-1:0] neighbor_site;
        logic [DIR_W-1:0]  direction;
        logic              last_of_run;
        logic              bad_index;
    } nbr_item_t;

    // expected neighbour items and the side length they are worked out with
    class nbr_scoreboard;
        logic [SIDE_IN_W-1:0] side_reg;
        nbr_item_t            due_q[$];
        int                   errors;

        function new();
            side_reg = SIDE_IN_W'(SIDE_RESET);
            errors   = 0;
        endfunction

        function void set_side(logic [SIDE_IN_W-1:0] value);
            side_reg = value;
        endfunction

        // side length as the block applies it: zero means one, clamp at the top
        function int eff_side();
            int s;
            s = int'(side_reg);
            if (s == 0) s = 1;
            if (s > MAX_SIDE) s = MAX_SIDE;
            return s;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // work out the 2*AXES neighbour items of one accepted site
        function void note_site(logic [SITE_W-1:0] site);
            int        s;
            int        vol;
            int        rest;
            int        idx;
            int        c;
            int        nb;
            int        stride [AXES];
            int        coord  [AXES];
            bit        bad;
            nbr_item_t r;
            s   = eff_side();
            idx = int'(site);
            vol = 1;
            for (int a = AXES - 1; a >= 0; a--)
            begin
                stride[a] = vol;
                vol       = vol * s;
            end
            bad  = (idx >= vol);
            rest = idx;
            for (int a = AXES - 1; a >= 0; a--)
            begin
                coord[a] = rest % s;
                rest     = rest / s;
            end
            for (int a = 0; a < AXES; a++)
            begin
                c = coord[a];
                for (int k = 0; k < 2; k++)
                begin
                    if (k == 0)
                        nb = (c == 0) ? idx + (s - 1) * stride[a] : idx - stride[a];
                    else
                        nb = (c == s - 1) ? idx - (s - 1) * stride[a] : idx + stride[a];
                    r.neighbor_site = bad ? '0 : SITE_W'(nb);
                    r.direction     = DIR_W'(2 * a + k);
                    r.last_of_run   = (2 * a + k == 2 * AXES - 1);
                    r.bad_index     = bad;
                    due_q = {due_q, r};
                end
            end
        endfunction

        // compare one delivered neighbour item with the oldest expectation
        function void check_result(nbr_item_t got);
            nbr_item_t want;
            if (due_q.size() == 0)
            begin
                $display("%0t unexpected item: expected none actual site %0d dir %0d",
                         $time, got.neighbor_site, got.direction);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (got.neighbor_site !== want.neighbor_site)
            begin
                $display("%0t neighbor_site mismatch: expected %0d actual %0d",
                         $time, want.neighbor_site, got.neighbor_site);
                errors++;
            end
            if (got.direction !== want.direction)
            begin
                $display("%0t direction mismatch: expected %0d actual %0d",
                         $time, want.direction, got.direction);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $display("%0t last_of_run mismatch: expected %0b actual %0b",
                         $time, want.last_of_run, got.last_of_run);
                errors++;
            end
            if (got.bad_index !== want.bad_index)
            begin
                $display("%0t bad_index mismatch: expected %0b actual %0b",
                         $time, want.bad_index, got.bad_index);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [SIDE_IN_W-1:0] cfg_wdata;
    bit                   quiet;
    nbr_scoreboard        sb;

    tlni_site_if site_ch ();
    tlni_nbr_if  nbr_ch ();

    torus_lattice_neighbor_index #(
        .AXES     (AXES),
        .MAX_SIDE (MAX_SIDE)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sites     (site_ch),
        .neighbors (nbr_ch)
    );

    // clock, 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: check accepted items, stall ready at random
    always @(posedge clk)
    begin
        if (rst_n && nbr_ch.valid && nbr_ch.ready)
            sb.check_result('{nbr_ch.neighbor_site, nbr_ch.direction,
                              nbr_ch.last_of_run, nbr_ch.bad_index});
        nbr_ch.ready <= quiet || ($urandom_range(0, 99) >= 11);
    end

    // send one site item, with a random gap first
    task automatic send_site(input logic [SITE_W-1:0] site);
        while (!quiet && $urandom_range(0, 99) < 11)
        begin
            site_ch.valid <= 1'b0;
            @(posedge clk);
        end
        site_ch.valid      <= 1'b1;
        site_ch.site_index <= site;
        do
            @(posedge clk);
        while (!site_ch.ready);
        sb.note_site(site);
    endtask

    // drop valid, wait for every expected item, then let the pipeline empty
    task automatic wait_idle();
        site_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // write the side length while the block is idle
    task automatic write_side(input logic [SIDE_IN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_side(value);
        @(posedge clk);
    endtask

    // random site: mostly inside the lattice, some on faces, some past the volume
    function automatic logic [SITE_W-1:0] pick_site();
        int s;
        int vol;
        int idx;
        int mode;
        int c;
        s   = sb.eff_side();
        vol = 1;
        for (int a = 0; a < AXES; a++)
            vol = vol * s;
        mode = $urandom_range(0, 99);
        if (mode < 10)
            return SITE_W'($urandom_range(0, (1 << SITE_W) - 1));
        if (mode < 16 && vol < (1 << SITE_W))
            return SITE_W'(vol + $urandom_range(0, 3));
        if (mode < 45)
        begin
            // coordinates on the faces of the lattice
            idx = 0;
            for (int a = 0; a < AXES; a++)
            begin
                case ($urandom_range(0, 2))
                    0:       c = 0;
                    1:       c = s - 1;
                    default: c = $urandom_range(0, s - 1);
                endcase
                idx = idx * s + c;
            end
            return SITE_W'(idx);
        end
        return SITE_W'($urandom_range(0, vol - 1));
    endfunction

    // main sequence
    initial
    begin
        logic [SIDE_IN_W-1:0] side_val;
        sb                 = new();
        quiet              = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        site_ch.valid      = 1'b0;
        site_ch.site_index = '0;
        nbr_ch.ready       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset side length: first corner, an inner site, last valid site, first bad site, all ones
        send_site(18'd0);
        send_site(18'd21);
        send_site(18'd63);
        send_site(18'd64);
        send_site(18'h3FFFF);
        wait_idle();

        // side length one: every neighbour of site zero is the site itself, site one is bad
        write_side(7'd1);
        send_site(18'd0);
        send_site(18'd1);
        wait_idle();

        // largest side: whole index range valid
        write_side(7'd64);
        send_site(18'd0);
        send_site(18'h3FFFF);
        send_site(18'd4095);
        send_site(18'd258048);
        send_site(18'd63);
        wait_idle();

        // zero is used as one
        write_side(7'd0);
        send_site(18'd0);
        send_site(18'd3);
        wait_idle();

        // above the maximum is clamped
        write_side(7'h7F);
        send_site(18'h3FFFF);
        send_site(18'd131072);
        wait_idle();

        write_side(7'd2);
        send_site(18'd7);
        send_site(18'd8);
        send_site(18'd5);
        wait_idle();

        // random phases, one of them without any idling
        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0:       side_val = 7'd64;
                3:       side_val = SIDE_IN_W'($urandom_range(MAX_SIDE + 1, 127));
                6:       side_val = 7'd0;
                default: side_val = SIDE_IN_W'($urandom_range(1, MAX_SIDE));
            endcase
            write_side(side_val);
            quiet = (p == 4);
            for (int i = 0; i < 17; i++)
                send_site(pick_site());
            wait_idle();
            quiet = 1'b0;
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
